>>> hdl/ial_pkg.sv
// ----------------------------------------------------------------------------
// ial_pkg
// Shared types and constants for the indexed array list core: operation
// codes, controller commands and the datapath status bundle.
// ----------------------------------------------------------------------------
package ial_pkg;

	// default number of list entries
	localparam int CAPACITY_DEF = 256;
	// width of one stored word
	localparam int WORD_W       = 32;
	// width of the operation code
	localparam int OP_W         = 3;

	// request operation codes
	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 3'd0,
		OP_INSERT = 3'd1,
		OP_UPDATE = 3'd2,
		OP_REMOVE = 3'd3,
		OP_GET    = 3'd4,
		OP_CLEAR  = 3'd5
	} op_t;

	// commands from controller to datapath
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_APPEND,
		CMD_UPDATE,
		CMD_CLEAR,
		CMD_FAIL,
		CMD_READ,
		CMD_INS_START,
		CMD_INS_STEP,
		CMD_INS_END,
		CMD_REM_START,
		CMD_REM_STEP,
		CMD_REM_END,
		CMD_POST
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            pos_lt_cnt;
		logic            pos_le_cnt;
		logic            pos_eq_cnt;
		logic            pos_at_top;
		logic            ptr_at_pos;
		logic            ptr_at_top;
	} status_t;

endpackage

>>> hdl/ial_datapath.sv
// ----------------------------------------------------------------------------
// ial_datapath
// Element store, count register, shift pointer and result registers. Runs
// one command per cycle from the controller and reports compare flags.
// ----------------------------------------------------------------------------
module ial_datapath #(
	parameter int CAPACITY = ial_pkg::CAPACITY_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1),
	localparam int ADDR_W  = $clog2(CAPACITY)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ial_pkg::cmd_t              cmd,
	output ial_pkg::status_t           st,
	input  logic [ial_pkg::OP_W-1:0]   operation,
	input  logic [CNT_W-1:0]           position,
	input  logic signed [ial_pkg::WORD_W-1:0] word_in,
	output logic signed [ial_pkg::WORD_W-1:0] word_out,
	output logic                       ok,
	output logic [CNT_W-1:0]           count_out
);
	import ial_pkg::*;

	localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

	logic [WORD_W-1:0] mem [CAPACITY];

	logic [OP_W-1:0]   op_q;
	logic [CNT_W-1:0]  pos_q;
	logic [WORD_W-1:0] word_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  ptr_q;
	logic [WORD_W-1:0] res_word_q;
	logic              res_ok_q;
	logic [WORD_W-1:0] out_word_q;
	logic              out_ok_q;
	logic [CNT_W-1:0]  out_count_q;

	logic [WORD_W-1:0] rd_data_s1;
	logic              pend_s1;
	logic              cap_s1;
	logic [ADDR_W-1:0] wr_addr_s1;

	logic [CNT_W-1:0]  ptr_inc;
	logic [CNT_W-1:0]  ptr_dec;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CNT_W:0]    pos_ext_inc;
	logic [CNT_W:0]    ptr_ext_inc;
	logic              we;
	logic [ADDR_W-1:0] wa;
	logic [WORD_W-1:0] wd;
	logic              re;
	logic [ADDR_W-1:0] ra;

	assign ptr_inc     = ptr_q + CNT_W'(1);
	assign ptr_dec     = ptr_q - CNT_W'(1);
	assign cnt_dec     = count_q - CNT_W'(1);
	assign pos_ext_inc = {1'b0, pos_q} + (CNT_W + 1)'(1);
	assign ptr_ext_inc = {1'b0, ptr_q} + (CNT_W + 1)'(1);

	// compare flags for the controller
	always_comb begin
		st.op         = op_q;
		st.full       = (count_q == CAP_CNT);
		st.pos_lt_cnt = (pos_q < count_q);
		st.pos_le_cnt = (pos_q <= count_q);
		st.pos_eq_cnt = (pos_q == count_q);
		st.pos_at_top = (pos_ext_inc == {1'b0, count_q});
		st.ptr_at_pos = (ptr_q == pos_q);
		st.ptr_at_top = (ptr_ext_inc == {1'b0, count_q});
	end

	// write port: a pending shift write has priority, others never overlap it
	always_comb begin
		we = 1'b0;
		wa = pos_q[ADDR_W-1:0];
		wd = word_q;
		if (pend_s1) begin
			we = 1'b1;
			wa = wr_addr_s1;
			wd = rd_data_s1;
		end else begin
			case (cmd)
				CMD_APPEND: begin
					we = 1'b1;
					wa = count_q[ADDR_W-1:0];
				end
				CMD_UPDATE,
				CMD_INS_END: begin
					we = 1'b1;
				end
				default: begin
					we = 1'b0;
				end
			endcase
		end
	end

	// read port
	always_comb begin
		re = 1'b0;
		ra = ptr_q[ADDR_W-1:0];
		case (cmd)
			CMD_READ,
			CMD_REM_START: begin
				re = 1'b1;
				ra = pos_q[ADDR_W-1:0];
			end
			CMD_INS_STEP,
			CMD_REM_STEP: begin
				re = 1'b1;
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	// element store with registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		if (re) begin
			rd_data_s1 <= mem[ra];
		end
	end

	// shift write address, registered so that it lines up with the read data
	always_ff @(posedge clk) begin
		if (cmd == CMD_INS_STEP) begin
			wr_addr_s1 <= ptr_inc[ADDR_W-1:0];
		end else begin
			wr_addr_s1 <= ptr_dec[ADDR_W-1:0];
		end
	end

	// pending write and capture flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1 <= 1'b0;
			cap_s1  <= 1'b0;
		end else begin
			pend_s1 <= (cmd == CMD_INS_STEP) || (cmd == CMD_REM_STEP);
			cap_s1  <= (cmd == CMD_READ) || (cmd == CMD_REM_START);
		end
	end

	// element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd)
				CMD_APPEND,
				CMD_INS_END: count_q <= count_q + CNT_W'(1);
				CMD_REM_END: count_q <= cnt_dec;
				CMD_CLEAR:   count_q <= '0;
				default:     count_q <= count_q;
			endcase
		end
	end

	// request capture, pointer and result
	always_ff @(posedge clk) begin
		if (cap_s1) begin
			res_word_q <= rd_data_s1;
		end
		case (cmd)
			CMD_LOAD: begin
				op_q   <= operation;
				pos_q  <= position;
				word_q <= word_in;
			end
			CMD_APPEND,
			CMD_UPDATE,
			CMD_CLEAR,
			CMD_INS_END: begin
				res_ok_q   <= 1'b1;
				res_word_q <= '0;
			end
			CMD_FAIL: begin
				res_ok_q   <= 1'b0;
				res_word_q <= '0;
			end
			CMD_READ: begin
				res_ok_q <= 1'b1;
			end
			CMD_INS_START: begin
				ptr_q <= cnt_dec;
			end
			CMD_INS_STEP: begin
				ptr_q <= ptr_dec;
			end
			CMD_REM_START: begin
				res_ok_q <= 1'b1;
				ptr_q    <= pos_ext_inc[CNT_W-1:0];
			end
			CMD_REM_STEP: begin
				ptr_q <= ptr_inc;
			end
			CMD_POST: begin
				out_word_q  <= res_word_q;
				out_ok_q    <= res_ok_q;
				out_count_q <= count_q;
			end
			default: begin
				ptr_q <= ptr_q;
			end
		endcase
	end

	assign word_out  = out_word_q;
	assign ok        = out_ok_q;
	assign count_out = out_count_q;

endmodule

>>> hdl/ial_ctrl.sv
// ----------------------------------------------------------------------------
// ial_ctrl
// Request sequencer: decodes the captured operation, walks the shift loop
// for insert and remove, and owns both handshakes.
// ----------------------------------------------------------------------------
module ial_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ial_pkg::status_t  st,
	output ial_pkg::cmd_t     cmd
);
	import ial_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_WAIT,
		S_INS_SHIFT,
		S_INS_DRAIN,
		S_INS_END,
		S_REM_SHIFT,
		S_REM_END,
		S_POST
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// command and next state
	always_comb begin
		cmd     = CMD_NONE;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd     = CMD_LOAD;
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_POST;
				case (st.op)
					OP_APPEND: begin
						cmd = st.full ? CMD_FAIL : CMD_APPEND;
					end
					OP_INSERT: begin
						if (!st.pos_le_cnt || st.full) begin
							cmd = CMD_FAIL;
						end else if (st.pos_eq_cnt) begin
							cmd = CMD_INS_END;
						end else begin
							cmd     = CMD_INS_START;
							state_d = S_INS_SHIFT;
						end
					end
					OP_UPDATE: begin
						cmd = st.pos_lt_cnt ? CMD_UPDATE : CMD_FAIL;
					end
					OP_REMOVE: begin
						if (st.pos_lt_cnt) begin
							cmd     = CMD_REM_START;
							state_d = st.pos_at_top ? S_REM_END : S_REM_SHIFT;
						end else begin
							cmd = CMD_FAIL;
						end
					end
					OP_GET: begin
						if (st.pos_lt_cnt) begin
							cmd     = CMD_READ;
							state_d = S_WAIT;
						end else begin
							cmd = CMD_FAIL;
						end
					end
					OP_CLEAR: begin
						cmd = CMD_CLEAR;
					end
					default: begin
						cmd = CMD_FAIL;
					end
				endcase
			end
			S_WAIT: begin
				state_d = S_POST;
			end
			S_INS_SHIFT: begin
				cmd = CMD_INS_STEP;
				if (st.ptr_at_pos) begin
					state_d = S_INS_DRAIN;
				end
			end
			S_INS_DRAIN: begin
				state_d = S_INS_END;
			end
			S_INS_END: begin
				cmd     = CMD_INS_END;
				state_d = S_POST;
			end
			S_REM_SHIFT: begin
				cmd = CMD_REM_STEP;
				if (st.ptr_at_top) begin
					state_d = S_REM_END;
				end
			end
			S_REM_END: begin
				cmd     = CMD_REM_END;
				state_d = S_POST;
			end
			S_POST: begin
				if (out_free) begin
					cmd     = CMD_POST;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd == CMD_POST) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> hdl/indexed_array_list_core.sv
// ----------------------------------------------------------------------------
// indexed_array_list_core
// Ordered list of signed words in a fixed store with append, insert, update,
// remove, get and clear, one result per request.
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  request   in_valid/in_ready, operation, position,   in
//            word_in
//  result    out_valid/out_ready, word_out, ok,        out
//            count_out
//
// append, update, clear, end inserts and failed requests go straight to
// posting; get waits for the read; remove shifts unless it takes the last
// entry, then ends; other inserts shift, drain and end. The shift loop does
// one read and one write of the single-port-pair store per moved entry; the
// next request is taken the cycle after posting.
// Reset clears the count and the handshake state; the store needs no clear.
// A stalled result holds in the output register while the next request is
// taken and run; it is posted once the register is free.
module indexed_array_list_core #(
	parameter int CAPACITY = ial_pkg::CAPACITY_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ial_pkg::OP_W-1:0]          operation,
	input  logic [CNT_W-1:0]                  position,
	input  logic signed [ial_pkg::WORD_W-1:0] word_in,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [ial_pkg::WORD_W-1:0] word_out,
	output logic                              ok,
	output logic [CNT_W-1:0]                  count_out
);
	import ial_pkg::*;

	cmd_t    cmd;
	status_t st;

	// sequencer
	ial_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	// store and result registers
	ial_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.operation (operation),
		.position  (position),
		.word_in   (word_in),
		.word_out  (word_out),
		.ok        (ok),
		.count_out (count_out)
	);

endmodule

>>> hdl/ial_checker.sv
// ----------------------------------------------------------------------------
// ial_checker
// Port-level checks for the indexed array list core, bound to the top level.
// ----------------------------------------------------------------------------
module ial_checker #(
	parameter int CAPACITY = ial_pkg::CAPACITY_DEF,
	localparam int CNT_W   = $clog2(CAPACITY + 1)
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic signed [ial_pkg::WORD_W-1:0] word_out,
	input logic                              ok,
	input logic [CNT_W-1:0]                  count_out
);
	import ial_pkg::*;

	// a stalled result holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(word_out) && $stable(ok)
			&& $stable(count_out))
		else $error("result changed while stalled");

	// a failed request returns a zero word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> word_out == '0)
		else $error("failed result carries nonzero word");

	// the reported count never exceeds the store size
	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_out <= CNT_W'(CAPACITY))
		else $error("count above capacity");

	// one request at a time: busy right after a request transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

endmodule

bind indexed_array_list_core ial_checker #(
	.CAPACITY (CAPACITY)
) u_ial_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.word_out  (word_out),
	.ok        (ok),
	.count_out (count_out)
);

>>> dv/ial_list_checker.sv
// ----------------------------------------------------------------------------
// ial_list_checker
// Watches the request and result channels of the indexed array list core,
// keeps its own copy of the list to work out the result of each request,
// and compares every result field by field with the oldest one due.
// ----------------------------------------------------------------------------
module ial_list_checker
	import ial_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_ready,
	input  logic [OP_W-1:0]          operation,
	input  logic [CNT_W-1:0]         position,
	input  logic signed [WORD_W-1:0] word_in,
	input  logic                     out_valid,
	input  logic                     out_ready,
	input  logic signed [WORD_W-1:0] word_out,
	input  logic                     ok,
	input  logic [CNT_W-1:0]         count_out,
	output int                       mismatches,
	output int                       outstanding,
	output int                       held_count
);

	// one result as the list should report it
	typedef struct packed {
		logic [OP_W-1:0]          code;
		logic signed [WORD_W-1:0] word;
		logic                     ok;
		logic [CNT_W-1:0]         count;
	} list_result_t;

	// shadow copy of the list
	logic signed [WORD_W-1:0] list_words [CAPACITY];
	int                       list_len;

	list_result_t due_results [$];
	list_result_t new_result;
	list_result_t oldest;

	// apply one request to the shadow list and work out its result
	task automatic apply_request(
		input  logic [OP_W-1:0]          code,
		input  logic [CNT_W-1:0]         pos,
		input  logic signed [WORD_W-1:0] word,
		output list_result_t             res
	);
		int j;
		res.code = code;
		res.word = '0;
		res.ok   = 1'b0;
		case (code)
			OP_APPEND: begin
				if (list_len < CAPACITY) begin
					list_words[list_len] = word;
					list_len++;
					res.ok = 1'b1;
				end
			end
			OP_INSERT: begin
				// insert at the end behaves as append
				if (pos <= list_len && list_len < CAPACITY) begin
					for (j = list_len; j > pos; j--)
						list_words[j] = list_words[j-1];
					list_words[pos] = word;
					list_len++;
					res.ok = 1'b1;
				end
			end
			OP_UPDATE: begin
				if (pos < list_len) begin
					list_words[pos] = word;
					res.ok = 1'b1;
				end
			end
			OP_REMOVE: begin
				if (pos < list_len) begin
					res.word = list_words[pos];
					for (j = pos; j + 1 < list_len; j++)
						list_words[j] = list_words[j+1];
					list_len--;
					res.ok = 1'b1;
				end
			end
			OP_GET: begin
				if (pos < list_len) begin
					res.word = list_words[pos];
					res.ok   = 1'b1;
				end
			end
			OP_CLEAR: begin
				list_len = 0;
				res.ok   = 1'b1;
			end
			// unused codes change nothing and fail
			default: ;
		endcase
		res.count = CNT_W'(list_len);
	endtask

	// track requests and check results on each transfer
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			due_results.delete();
			list_len    = 0;
			outstanding = 0;
			held_count  = 0;
			mismatches  = 0;
		end else begin
			if (in_valid === 1'b1 && in_ready === 1'b1) begin
				apply_request(operation, position, word_in, new_result);
				due_results.push_back(new_result);
			end
			if (out_valid === 1'b1 && out_ready === 1'b1) begin
				if (due_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: word=%0d ok=%0b count=%0d",
							word_out, ok, count_out);
				end else begin
					oldest = due_results.pop_front();
					if (word_out !== oldest.word || ok !== oldest.ok ||
						count_out !== oldest.count) begin
						mismatches++;
						if (mismatches <= 10)
							$display({"mismatch op=%0d: expected word=%0d ok=%0b ",
								"count=%0d, got word=%0d ok=%0b count=%0d"},
								oldest.code, oldest.word, oldest.ok, oldest.count,
								word_out, ok, count_out);
					end
				end
			end
			outstanding = due_results.size();
			held_count  = list_len;
		end
	end

endmodule

>>> dv/tb_indexed_array_list_core.sv
// ----------------------------------------------------------------------------
// tb_indexed_array_list_core
// Drives requests into the indexed array list core: a directed opening on
// the edge cases, then phases of random traffic that grow, shrink, fill and
// churn the list, with random gaps and result stalls. A checker beside the
// core predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_indexed_array_list_core;
	import ial_pkg::*;

	localparam int CAPACITY     = CAPACITY_DEF;
	localparam int CNT_W        = $clog2(CAPACITY + 1);
	localparam int RANDOM_ITEMS = 1400;
	localparam int DRAIN_CYCLES = 300;

	// codes outside the defined operations
	localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
	localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

	typedef enum {PH_MIXED, PH_GROW, PH_SHRINK, PH_FILL} phase_t;

	logic                     clk       = 1'b0;
	logic                     arst_n    = 1'b0;
	logic                     in_valid  = 1'b0;
	logic                     in_ready;
	logic [OP_W-1:0]          operation = '0;
	logic [CNT_W-1:0]         position  = '0;
	logic signed [WORD_W-1:0] word_in   = '0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [WORD_W-1:0] word_out;
	logic                     ok;
	logic [CNT_W-1:0]         count_out;

	int mismatches;
	int outstanding;
	int held_count;
	bit no_gaps = 1'b0;

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	indexed_array_list_core #(.CAPACITY(CAPACITY)) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.operation (operation),
		.position  (position),
		.word_in   (word_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.word_out  (word_out),
		.ok        (ok),
		.count_out (count_out)
	);

	ial_list_checker #(.CAPACITY(CAPACITY)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.position    (position),
		.word_in     (word_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.word_out    (word_out),
		.ok          (ok),
		.count_out   (count_out),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.held_count  (held_count)
	);

	// one request transfer after a random gap; returns at a falling edge
	task automatic send_request(
		input logic [OP_W-1:0]          code,
		input logic [CNT_W-1:0]         pos,
		input logic signed [WORD_W-1:0] word
	);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		operation = code;
		position  = pos;
		word_in   = word;
		in_valid  = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	// hold off requests until every result is back
	task automatic wait_for_results();
		in_valid = 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	function automatic logic [OP_W-1:0] pick_op(phase_t kind, int cnt);
		int r;
		r = $urandom_range(0, 99);
		// grow only while the list is short, so shifts stay cheap
		if (kind == PH_GROW && cnt < 48) begin
			if (r < 40) return OP_APPEND;
			if (r < 80) return OP_INSERT;
			if (r < 90) return OP_GET;
			return OP_UPDATE;
		end
		if (kind == PH_SHRINK) begin
			if (r < 60) return OP_REMOVE;
			if (r < 75) return OP_GET;
			if (r < 85) return OP_UPDATE;
			if (r < 95) return OP_APPEND;
			return OP_INSERT;
		end
		if (r < 15) return OP_APPEND;
		if (r < 30) return OP_INSERT;
		if (r < 45) return OP_UPDATE;
		if (r < 70) return OP_REMOVE;
		if (r < 92) return OP_GET;
		if (r < 95) return OP_CLEAR;
		if (r < 98) return OP_SPARE_LO;
		return OP_SPARE_HI;
	endfunction

	// mostly legal indexes, some at the end, some anywhere in the field
	function automatic logic [CNT_W-1:0] pick_pos(logic [OP_W-1:0] code, int cnt);
		int r;
		int hi;
		hi = (code == OP_INSERT) ? cnt : cnt - 1;
		r  = $urandom_range(0, 99);
		if (r < 70 && hi >= 0) return CNT_W'($urandom_range(0, hi));
		if (r < 80) return CNT_W'(cnt);
		if (r < 88) return '0;
		return CNT_W'($urandom_range(0, 2**CNT_W - 1));
	endfunction

	function automatic logic signed [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 15))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	// result side: random stall before taking each result
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 5);
			if (stall != 0) begin
				out_ready = 1'b0;
				do @(posedge clk); while (out_valid !== 1'b1);
				repeat (stall) @(negedge clk);
			end
			out_ready = 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	// request side and verdict
	initial begin
		int               random_sent;
		int               phase_len;
		int               phase_no;
		int               fills_done;
		phase_t           kind;
		logic [OP_W-1:0]  code;
		random_sent = 0;
		phase_no    = 0;
		fills_done  = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// requests against an empty list
		send_request(OP_GET,    0, 0);
		send_request(OP_REMOVE, 0, 0);
		send_request(OP_UPDATE, 0, 32'sh1111_1111);
		send_request(OP_INSERT, 1, 32'sh2222_2222);
		// insert at the end, then appends of the extreme words
		send_request(OP_INSERT, 0, 32'sh7fff_ffff);
		send_request(OP_APPEND, 0, 32'sh8000_0000);
		send_request(OP_APPEND, 0, 0);
		send_request(OP_APPEND, 0, -32'sd1);
		// insert in the middle, at the end, past the end
		send_request(OP_INSERT, 1, 32'sh1234_5678);
		send_request(OP_INSERT, 5, 32'sha5a5_a5a5);
		send_request(OP_INSERT, 7, 32'sh3333_3333);
		// reads, good and bad
		send_request(OP_GET, 0,   0);
		send_request(OP_GET, 5,   0);
		send_request(OP_GET, 6,   0);
		send_request(OP_GET, 256, 0);
		send_request(OP_GET, 511, 0);
		// update good and bad
		send_request(OP_UPDATE, 2, 32'sh5a5a_5a5a);
		send_request(OP_UPDATE, 6, 32'sh4444_4444);
		// remove first, last and past the end
		send_request(OP_REMOVE, 0, 0);
		send_request(OP_REMOVE, 4, 0);
		send_request(OP_REMOVE, 9, 0);
		// unused codes, the first with every field bit set
		send_request(OP_SPARE_LO, 511, -32'sd1);
		send_request(OP_SPARE_HI, 0,   32'sh7fff_ffff);
		// clear a list, then an empty one
		send_request(OP_CLEAR, 0, 0);
		send_request(OP_CLEAR, 0, 0);
		wait_for_results();

		// random phases
		while (random_sent < RANDOM_ITEMS) begin
			// a fill phase only starts while its whole length still fits
			if ((phase_no == 2 || (fills_done < 2 && $urandom_range(0, 14) == 0)) &&
				random_sent <= RANDOM_ITEMS - 500)
				kind = PH_FILL;
			else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: kind = PH_MIXED;
					4, 5, 6:    kind = PH_GROW;
					default:    kind = PH_SHRINK;
				endcase
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 2) == 0)
				wait_for_results();

			if (kind == PH_FILL) begin
				fills_done++;
				// fill to capacity
				while (held_count < CAPACITY) begin
					code = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
					send_request(code, CNT_W'($urandom_range(0, held_count)), pick_word());
					random_sent++;
				end
				// requests against a full store
				repeat (12) begin
					case ($urandom_range(0, 3))
						0:       code = OP_APPEND;
						1:       code = OP_INSERT;
						2:       code = OP_GET;
						default: code = OP_UPDATE;
					endcase
					send_request(code, pick_pos(code, held_count), pick_word());
					random_sent++;
				end
				// drain back to a short list
				while (held_count > 32) begin
					send_request(OP_REMOVE, CNT_W'($urandom_range(0, held_count - 1)),
						pick_word());
					random_sent++;
				end
			end else begin
				phase_len = $urandom_range(30, 80);
				// last phase stops at the item budget
				if (phase_len > RANDOM_ITEMS - random_sent)
					phase_len = RANDOM_ITEMS - random_sent;
				repeat (phase_len) begin
					code = pick_op(kind, held_count);
					send_request(code, pick_pos(code, held_count), pick_word());
					random_sent++;
				end
			end
			phase_no++;
		end

		// drain and let any stray result show up
		no_gaps = 1'b0;
		wait_for_results();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// timeout
	initial begin
		#8000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
